// ===== rtl/sorted_active_error_table_core_assert.svh =====
// Assertion macros shared by the sorted active error table RTL.
`ifndef SORTED_ACTIVE_ERROR_TABLE_CORE_ASSERT_SVH
`define SORTED_ACTIVE_ERROR_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define SAET_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("saet assertion failed");

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low.
`define SAET_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("saet assertion failed");

`endif

// ===== rtl/saet_pkg.sv =====
// Package: sizes, operation codes and controller command type for the error table.
`default_nettype none

package saet_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned CodeWidth = 16;
  localparam int unsigned OpWidth   = 3;
  localparam int unsigned IdxWidth  = 4;
  localparam int unsigned CntWidth  = 5;

  typedef logic [CodeWidth-1:0] code_t;
  typedef logic [OpWidth-1:0]   op_t;
  typedef logic [IdxWidth-1:0]  idx_t;
  typedef logic [CntWidth-1:0]  cnt_t;

  // Operation codes; the remaining codes leave the table unchanged
  localparam op_t OpSave   = 3'd0;
  localparam op_t OpDelete = 3'd1;
  localparam op_t OpFind   = 3'd2;
  localparam op_t OpClear  = 3'd3;
  localparam op_t OpRead   = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic execute;   // apply the latched request to the table
  } saet_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/saet_req_if.sv =====
// Request channel interface: valid/ready handshake with operation, code and index.
`default_nettype none

interface saet_req_if;
  import saet_pkg::*;

  logic  valid;
  logic  ready;
  op_t   operation;
  code_t code;
  idx_t  index;

  modport source (output valid, output operation, output code, output index, input ready);
  modport sink   (input valid, input operation, input code, input index, output ready);
endinterface

`default_nettype wire

// ===== rtl/saet_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the result fields.
`default_nettype none

interface saet_rsp_if;
  import saet_pkg::*;

  logic  valid;
  logic  ready;
  logic  hit;
  code_t entry_value;
  code_t lowest_code;
  cnt_t  active_count;

  modport source (output valid, output hit, output entry_value, output lowest_code,
                  output active_count, input ready);
  modport sink   (input valid, input hit, input entry_value, input lowest_code,
                  input active_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/saet_ctrl.sv =====
// Controller: sequences capture, execute and response hand-off for each request.
`default_nettype none

module saet_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output saet_pkg::saet_cmd_t      cmd_o
);
  import saet_pkg::*;

  `include "sorted_active_error_table_core_assert.svh"

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StResp = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // A new request is taken when idle, or as the pending result is taken
  assign in_ready_o  = (state_q == StIdle) || ((state_q == StResp) && out_ready_i);
  assign out_valid_o = (state_q == StResp);
  assign accept      = in_valid_i && in_ready_o;

  assign cmd_o.capture = accept;
  assign cmd_o.execute = (state_q == StExec);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StExec;
      end
      StExec: begin
        state_d = StResp;
      end
      StResp: begin
        if (out_ready_i) state_d = accept ? StExec : StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `SAET_ASSERT_NXT(a_exec_one_cycle, state_q == StExec, state_q == StResp)
  `SAET_ASSERT_IMP(a_no_take_in_exec, state_q == StExec, !in_ready_o && !out_valid_o)
  `SAET_ASSERT_NXT(a_take_goes_exec, accept, state_q == StExec)

endmodule

`default_nettype wire

// ===== rtl/saet_dp.sv =====
// Datapath: sorted code table with parallel compare, insert and delete shifting.
`default_nettype none

module saet_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire saet_pkg::saet_cmd_t cmd_i,
  input  wire saet_pkg::op_t       operation_i,
  input  wire saet_pkg::code_t     code_i,
  input  wire saet_pkg::idx_t      index_i,
  output logic                     hit_o,
  output saet_pkg::code_t          entry_value_o,
  output saet_pkg::code_t          lowest_code_o,
  output saet_pkg::cnt_t           active_count_o
);
  import saet_pkg::*;

  `include "sorted_active_error_table_core_assert.svh"

  // Latched request
  op_t   op_q;
  code_t code_q;
  idx_t  idx_q;

  // Table state
  code_t table_q [Depth];
  code_t table_d [Depth];
  cnt_t  cnt_q, cnt_d;
  logic  hit_q;

  logic [Depth-1:0] lt;     // live entry below the code
  logic [Depth-1:0] eq;     // entry equals the code
  code_t up_v   [Depth];    // table with the code inserted
  code_t down_v [Depth];    // table with the code removed
  logic  hit_now;
  logic  full;
  logic  ins_ok;
  logic  del_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      code_q <= code_i;
      idx_q  <= index_i;
    end
  end

  // Parallel compares against every slot
  for (genvar i = 0; i < Depth; i++) begin : g_cmp
    assign lt[i] = (table_q[i] != '0) && (table_q[i] < code_q);
    assign eq[i] = (table_q[i] == code_q);
  end

  // For code zero this reports a free slot, as an empty slot holds zero
  assign hit_now = |eq;
  assign full    = (table_q[Depth-1] != '0);
  assign ins_ok  = (code_q != '0) && !hit_now && (!full || (table_q[Depth-1] > code_q));
  assign del_ok  = (code_q != '0) && hit_now;

  // Shifted views: live entries below the code stay, the rest move one slot
  for (genvar j = 0; j < Depth; j++) begin : g_shift
    if (j == 0) begin : g_first
      assign up_v[j] = lt[j] ? table_q[j] : code_q;
    end else begin : g_rest
      assign up_v[j] = lt[j] ? table_q[j] : (lt[j-1] ? code_q : table_q[j-1]);
    end
    if (j == Depth - 1) begin : g_last
      assign down_v[j] = lt[j] ? table_q[j] : '0;
    end else begin : g_inner
      assign down_v[j] = lt[j] ? table_q[j] : table_q[j+1];
    end
  end

  // Table update decode
  always_comb begin
    table_d = table_q;
    cnt_d   = cnt_q;
    unique case (op_q)
      OpSave: begin
        if (ins_ok) begin
          table_d = up_v;
          if (!full) cnt_d = cnt_q + cnt_t'(1);
        end
      end
      OpDelete: begin
        if (del_ok) begin
          table_d = down_v;
          cnt_d   = cnt_q - cnt_t'(1);
        end
      end
      OpClear: begin
        for (int k = 0; k < Depth; k++) table_d[k] = '0;
        cnt_d = '0;
      end
      default: begin
        // find, read and unused codes leave the table as is
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) table_q[k] <= '0;
      cnt_q <= '0;
    end else if (cmd_i.execute) begin
      table_q <= table_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) hit_q <= hit_now;
  end

  // Result fields read straight from the updated state
  assign hit_o          = hit_q;
  assign entry_value_o  = table_q[idx_q];
  assign lowest_code_o  = table_q[0];
  assign active_count_o = cnt_q;

  `SAET_ASSERT_IMP(a_cnt_matches_head, 1'b1, (cnt_q == '0) == (table_q[0] == '0))
  `SAET_ASSERT_IMP(a_cnt_in_range, 1'b1, cnt_q <= cnt_t'(Depth))
  `SAET_ASSERT_NXT(a_clear_empties, cmd_i.execute && (op_q == OpClear), cnt_q == '0)

endmodule

`default_nettype wire

// ===== rtl/sorted_active_error_table_core.sv =====
// Top level of the sorted active error table: controller plus datapath.
// A request is captured on acceptance, applied in the execute state, and held valid until taken.
// Requests are not taken during the execute step, which updates all slots at once.
// Reset: asynchronous, active low; the table is emptied and the count cleared at once.
`default_nettype none

module sorted_active_error_table_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  saet_req_if.sink  req,
  saet_rsp_if.source rsp
);
  import saet_pkg::*;

  saet_cmd_t cmd;

  saet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .cmd_o      (cmd)
  );

  saet_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (req.operation),
    .code_i        (req.code),
    .index_i       (req.index),
    .hit_o         (rsp.hit),
    .entry_value_o (rsp.entry_value),
    .lowest_code_o (rsp.lowest_code),
    .active_count_o(rsp.active_count)
  );

endmodule

`default_nettype wire

// ===== tb/sv/error_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the error table: mirrors the table per request and compares every response.
module error_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  saet_req_if         req,
  saet_rsp_if         rsp,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import saet_pkg::*;

  typedef struct packed {
    logic  hit;
    code_t entry_value;
    code_t lowest_code;
    cnt_t  active_count;
  } table_rsp_t;

  code_t       mirror_tab [Depth];
  table_rsp_t  awaited_rsp_q [$];
  table_rsp_t  want;
  int unsigned fails;
  int unsigned k;

  assign fail_count_o = fails;

  // One line per problem; printing stops after a hundred but counting does not
  task automatic report_mismatch(input string msg);
    fails++;
    if (fails <= 100) $display("%0t ns: %s", $time, msg);
  endtask

  // Apply one request to the mirrored table and form the response it should give
  function automatic table_rsp_t apply_request(input op_t op, input code_t c, input idx_t ix);
    table_rsp_t r;
    int         pos;
    int         cnt;
    int         i;
    r.hit = 1'b0;
    for (i = 0; i < Depth; i++) begin
      if (mirror_tab[i] == c) r.hit = 1'b1;
    end
    case (op)
      OpSave: begin
        // zero and duplicates are ignored; a full table only takes codes below its largest
        if (c != '0 && !r.hit &&
            (mirror_tab[Depth-1] == '0 || mirror_tab[Depth-1] > c)) begin
          pos = 0;
          while (pos < Depth && mirror_tab[pos] != '0 && mirror_tab[pos] < c) pos++;
          for (i = Depth - 1; i > pos; i--) mirror_tab[i] = mirror_tab[i-1];
          mirror_tab[pos] = c;
        end
      end
      OpDelete: begin
        if (c != '0) begin
          pos = -1;
          for (i = 0; i < Depth; i++) begin
            if (pos < 0 && mirror_tab[i] == c) pos = i;
          end
          // close the gap
          if (pos >= 0) begin
            for (i = pos; i < Depth - 1; i++) mirror_tab[i] = mirror_tab[i+1];
            mirror_tab[Depth-1] = '0;
          end
        end
      end
      OpClear: begin
        for (i = 0; i < Depth; i++) mirror_tab[i] = '0;
      end
      default: ;  // find, read and the spare codes leave the table alone
    endcase
    cnt = 0;
    for (i = 0; i < Depth; i++) begin
      if (mirror_tab[i] != '0) cnt++;
    end
    r.active_count = cnt_t'(cnt);
    r.entry_value  = (ix < Depth) ? mirror_tab[ix] : '0;
    r.lowest_code  = mirror_tab[0];
    return r;
  endfunction

  initial fails = 0;

  // Response side first: a request accepted on this edge cannot be answered on it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_rsp_q.delete();
      for (k = 0; k < Depth; k++) mirror_tab[k] = '0;
      pending_o <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp.hit !== want.hit)
            report_mismatch($sformatf("hit: got %0d, expected %0d", rsp.hit, want.hit));
          if (rsp.entry_value !== want.entry_value)
            report_mismatch($sformatf("entry_value: got 0x%0h, expected 0x%0h",
                                      rsp.entry_value, want.entry_value));
          if (rsp.lowest_code !== want.lowest_code)
            report_mismatch($sformatf("lowest_code: got 0x%0h, expected 0x%0h",
                                      rsp.lowest_code, want.lowest_code));
          if (rsp.active_count !== want.active_count)
            report_mismatch($sformatf("active_count: got %0d, expected %0d",
                                      rsp.active_count, want.active_count));
        end
      end
      if (req.valid && req.ready)
        awaited_rsp_q.push_back(apply_request(req.operation, req.code, req.index));
      pending_o <= awaited_rsp_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the error table: clock, reset, request traffic, response stalls, verdict.
module tb;
  import saet_pkg::*;

  // Spare operation codes: the table must stay unchanged
  localparam op_t OpRsvd5 = 3'd5;
  localparam op_t OpRsvd7 = 3'd7;

  localparam int unsigned RandomRequests = 1950;
  localparam int unsigned PoolSize       = 24;
  localparam int unsigned LongStall      = 300;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned burst_left;
  bit          long_stall_go;
  code_t       code_pool [PoolSize];

  saet_req_if req_ch ();
  saet_rsp_if rsp_ch ();

  sorted_active_error_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  error_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one request; bursts of back-to-back requests separated by idle gaps
  task automatic send_request(input op_t op, input code_t c, input idx_t ix);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.code      <= c;
    req_ch.index     <= ix;
    burst_left--;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Mostly codes from a small pool so saves collide, deletes hit and the table fills
  function automatic code_t pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65)      return code_pool[$urandom_range(0, PoolSize - 1)];
    else if (r < 75) return code_t'($urandom_range(1, 40));
    else if (r < 87) return code_t'($urandom);
    else if (r < 92) return '0;
    else if (r < 96) return '1;
    else             return code_t'(1);
  endfunction

  // Response stalls: segments of always-ready, random, sparse and mostly-ready, one long hold
  initial begin : rsp_stall_gen
    int unsigned seg_len;
    int unsigned mode;
    bit          held_once;
    held_once    = 1'b0;
    rsp_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (long_stall_go && !held_once) begin
        // hold off long enough for the block to back up and stall requests
        held_once = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(5, 80);
      repeat (seg_len) begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= $urandom_range(0, 1);
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Request stimulus and verdict
  initial begin : req_stim
    int unsigned n;
    int unsigned r;
    int          v;
    op_t         op;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.operation = OpRead;
    req_ch.code      = '0;
    req_ch.index     = '0;
    burst_left       = 0;
    long_stall_go    = 1'b0;
    for (n = 0; n < PoolSize; n++) code_pool[n] = code_t'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, ignored saves, misses, spare ops, then fill and overflow
    send_request(OpFind,   16'h0000, 4'd0);   // free slot reported on empty table
    send_request(OpSave,   16'hFFFF, 4'd0);
    send_request(OpSave,   16'h0001, 4'd1);
    send_request(OpSave,   16'h0000, 4'd2);   // zero ignored
    send_request(OpSave,   16'h0001, 4'd0);   // duplicate ignored
    send_request(OpFind,   16'h1234, 4'd0);   // miss
    send_request(OpDelete, 16'h1234, 4'd0);   // delete of absent code
    send_request(OpDelete, 16'h0000, 4'd0);   // delete of zero
    send_request(OpRsvd5,  16'hFFFF, 4'd1);
    send_request(OpRsvd7,  16'h0001, 4'd15);
    for (v = 14; v >= 1; v--) send_request(OpSave, code_t'(v * 16'h0111), idx_t'(v));
    send_request(OpFind,   16'h0000, 4'd0);   // full: no free slot
    send_request(OpSave,   16'h8000, 4'd15);  // full, smaller: largest dropped
    send_request(OpSave,   16'hF000, 4'd15);  // full, larger: new code dropped
    send_request(OpDelete, 16'h0001, 4'd0);   // lowest removed, gap closed
    send_request(OpRead,   16'h0000, 4'd15);
    send_request(OpClear,  16'h0000, 4'd0);

    long_stall_go = 1'b1;

    // Random traffic with a pool refreshed now and then
    for (n = 0; n < RandomRequests; n++) begin
      if (n % 250 == 0) begin
        for (r = 0; r < PoolSize; r++) code_pool[r] = code_t'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 45)      op = OpSave;
      else if (r < 63) op = OpDelete;
      else if (r < 77) op = OpFind;
      else if (r < 91) op = OpRead;
      else if (r < 92) op = OpClear;
      else             op = op_t'($urandom_range(OpRsvd5, OpRsvd7));
      send_request(op, pick_code(), idx_t'($urandom_range(0, (1 << IdxWidth) - 1)));
    end
    req_ch.valid <= 1'b0;

    // Drain, then wait out anything stray
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
